### rtl/ssis_pkg.sv
package ssis_pkg;

  localparam int SEG_W   = 6;
  localparam int KEY_W   = 64;
  localparam int COUNT_W = 13;
  localparam int CFG_W   = 7;

  typedef logic [1:0]         status_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam status_t STATUS_OK      = 2'd0;
  localparam status_t STATUS_FULL    = 2'd1;
  localparam status_t STATUS_EMPTY   = 2'd2;
  localparam status_t STATUS_NOT_USE = 2'd3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam key_t KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam key_t KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

endpackage

### rtl/ssis_ram.sv
module ssis_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/sorted_segment_insert_store.sv
// Sorted segment store. Each segment keeps key/value pairs sorted by signed
// key; even segments are packed against their high end, odd ones against the
// low end. A request on the in_ channel either inserts a pair (operation 0) or
// asks for the smallest key of a segment (operation 1). Every request gives
// exactly one response on the out_ channel with a status, the neighbor keys
// of an inserted pair, the queried minimum and the total pair count.
// An insert walks the segment one slot per cycle through the key and value
// memories, moving each passed entry by one place. A new request is accepted
// only once the block is through with the last one and back in idle.
// The response is held in an output register, so a stalled receiver does not
// stop the next request from being accepted; the one after that waits until
// the held response is taken. cfg_we writes segments_in_use at once; the user
// must use it only while the block is idle, and the block does not enforce it.
// After reset the fill counts are cleared by a pass of one segment per cycle
// over min(MAX_SEGMENTS, 64) segments, during which in_ready stays low.
module sorted_segment_insert_store #(
  parameter int SEGMENT_CAPACITY = 64,
  parameter int MAX_SEGMENTS     = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [6:0]             cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_operation,
  input  logic [5:0]             in_segment,
  input  ssis_pkg::key_t         in_new_key,
  input  ssis_pkg::key_t         in_new_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ssis_pkg::status_t      out_status,
  output logic                   out_became_minimum,
  output ssis_pkg::key_t         out_predecessor_key,
  output ssis_pkg::key_t         out_successor_key,
  output ssis_pkg::key_t         out_minimum_key,
  output ssis_pkg::count_t       out_total_count
);

  import ssis_pkg::*;

  localparam int FILL_DEPTH  = (MAX_SEGMENTS < 2**SEG_W) ? MAX_SEGMENTS : 2**SEG_W;
  localparam int SEG_IDX_W   = $clog2(FILL_DEPTH);
  localparam int OFF_W       = $clog2(SEGMENT_CAPACITY);
  localparam int FILL_W      = $clog2(SEGMENT_CAPACITY + 1);
  localparam int STORE_DEPTH = SEGMENT_CAPACITY * FILL_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam logic [OFF_W-1:0]     LAST_OFF  = OFF_W'(SEGMENT_CAPACITY - 1);
  localparam logic [SEG_IDX_W-1:0] LAST_SEG  = SEG_IDX_W'(FILL_DEPTH - 1);
  localparam logic [FILL_W-1:0]    FILL_FULL = FILL_W'(SEGMENT_CAPACITY);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_WRITE = 3'd4;
  localparam logic [2:0] ST_QREAD = 3'd5;
  localparam logic [2:0] ST_RESP  = 3'd6;

  logic [2:0]           state_r, state_nxt;
  logic [SEG_IDX_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [CFG_W-1:0]     cfg_r, cfg_nxt;
  count_t               count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 op_r, op_nxt;
  logic [SEG_W-1:0]     seg_r, seg_nxt;
  key_t                 key_r, key_nxt;
  key_t                 val_r, val_nxt;
  logic [ADDR_W-1:0]    base_r, base_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [OFF_W-1:0]     i_r, i_nxt;
  logic                 moved_r, moved_nxt;
  logic                 bmin_r, bmin_nxt;
  key_t                 pred_r, pred_nxt;
  key_t                 succ_r, succ_nxt;
  key_t                 min_r, min_nxt;
  status_t              status_r, status_nxt;

  status_t              out_status_r, out_status_nxt;
  logic                 out_bmin_r, out_bmin_nxt;
  key_t                 out_pred_r, out_pred_nxt;
  key_t                 out_succ_r, out_succ_nxt;
  key_t                 out_min_r, out_min_nxt;
  count_t               out_count_r, out_count_nxt;

  logic                 key_we;
  logic [ADDR_W-1:0]    key_waddr, key_raddr;
  key_t                 key_wdata, val_wdata, key_rdata, val_rdata;
  logic                 fill_we;
  logic [SEG_IDX_W-1:0] fill_waddr, fill_raddr;
  logic [FILL_W-1:0]    fill_wdata, fill_rdata;

  logic [OFF_W-1:0]     start_off, query_off;
  logic                 load_out;

  ssis_ram #(.WIDTH(KEY_W), .DEPTH(STORE_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  ssis_ram #(.WIDTH(KEY_W), .DEPTH(STORE_DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (val_wdata),
    .raddr (key_raddr),
    .rdata (val_rdata)
  );

  ssis_ram #(.WIDTH(FILL_W), .DEPTH(FILL_DEPTH)) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .raddr (fill_raddr),
    .rdata (fill_rdata)
  );

  assign in_ready   = (state_r == ST_IDLE);
  assign fill_raddr = in_segment[SEG_IDX_W-1:0];
  assign start_off  = LAST_OFF - OFF_W'(fill_rdata);
  assign query_off  = LAST_OFF - OFF_W'(fill_rdata - 1'b1);
  assign load_out   = (state_r == ST_RESP) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    cfg_nxt     = cfg_we ? cfg_wdata : cfg_r;
    count_nxt   = count_r;
    op_nxt      = op_r;
    seg_nxt     = seg_r;
    key_nxt     = key_r;
    val_nxt     = val_r;
    base_nxt    = base_r;
    fill_nxt    = fill_r;
    i_nxt       = i_r;
    moved_nxt   = moved_r;
    bmin_nxt    = bmin_r;
    pred_nxt    = pred_r;
    succ_nxt    = succ_r;
    min_nxt     = min_r;
    status_nxt  = status_r;
    key_we      = 1'b0;
    key_waddr   = base_r + ADDR_W'(i_r);
    key_wdata   = key_r;
    val_wdata   = val_r;
    key_raddr   = base_r;
    fill_we     = 1'b0;
    fill_waddr  = seg_r[SEG_IDX_W-1:0];
    fill_wdata  = fill_r + 1'b1;

    case (state_r)
      ST_CLEAR: begin
        fill_we     = 1'b1;
        fill_waddr  = clr_idx_r;
        fill_wdata  = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_SEG) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_operation;
          seg_nxt    = in_segment;
          key_nxt    = in_new_key;
          val_nxt    = in_new_value;
          base_nxt   = ADDR_W'(32'(in_segment) * SEGMENT_CAPACITY);
          pred_nxt   = KEY_MIN;
          succ_nxt   = KEY_MAX;
          min_nxt    = '0;
          moved_nxt  = 1'b0;
          status_nxt = STATUS_OK;
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        fill_nxt = fill_rdata;
        if (({1'b0, seg_r} >= cfg_r) || (32'(seg_r) >= MAX_SEGMENTS)) begin
          status_nxt = STATUS_NOT_USE;
          state_nxt  = ST_RESP;
        end else if (op_r == OP_QUERY) begin
          if (fill_rdata == '0) begin
            status_nxt = STATUS_EMPTY;
            state_nxt  = ST_RESP;
          end else begin
            key_raddr = seg_r[0] ? base_r : base_r + ADDR_W'(query_off);
            state_nxt = ST_QREAD;
          end
        end else if (fill_rdata >= FILL_FULL) begin
          status_nxt = STATUS_FULL;
          state_nxt  = ST_RESP;
        end else if (!seg_r[0]) begin
          i_nxt = start_off;
          if (start_off == LAST_OFF) begin
            state_nxt = ST_WRITE;
          end else begin
            key_raddr = base_r + ADDR_W'(start_off) + 1'b1;
            state_nxt = ST_SCAN;
          end
        end else begin
          i_nxt = OFF_W'(fill_rdata);
          if (fill_rdata == '0) begin
            state_nxt = ST_WRITE;
          end else begin
            key_raddr = base_r + ADDR_W'(fill_rdata) - 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!seg_r[0]) begin
          if ($signed(key_rdata) < $signed(key_r)) begin
            key_we    = 1'b1;
            key_wdata = key_rdata;
            val_wdata = val_rdata;
            pred_nxt  = key_rdata;
            moved_nxt = 1'b1;
            i_nxt     = i_r + 1'b1;
            if (i_r + 1'b1 == LAST_OFF) begin
              state_nxt = ST_WRITE;
            end else begin
              key_raddr = base_r + ADDR_W'(i_r) + ADDR_W'(2);
            end
          end else begin
            succ_nxt  = key_rdata;
            state_nxt = ST_WRITE;
          end
        end else begin
          if ($signed(key_rdata) > $signed(key_r)) begin
            key_we    = 1'b1;
            key_wdata = key_rdata;
            val_wdata = val_rdata;
            succ_nxt  = key_rdata;
            moved_nxt = 1'b1;
            i_nxt     = i_r - 1'b1;
            if (i_r - 1'b1 == '0) begin
              state_nxt = ST_WRITE;
            end else begin
              key_raddr = base_r + ADDR_W'(i_r) - ADDR_W'(2);
            end
          end else begin
            pred_nxt  = key_rdata;
            state_nxt = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        key_we    = 1'b1;
        fill_we   = 1'b1;
        count_nxt = count_r + 1'b1;
        bmin_nxt  = seg_r[0] ? (i_r == '0) : !moved_r;
        state_nxt = ST_RESP;
      end
      ST_QREAD: begin
        min_nxt   = key_rdata;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_bmin_nxt   = out_bmin_r;
    out_pred_nxt   = out_pred_r;
    out_succ_nxt   = out_succ_r;
    out_min_nxt    = out_min_r;
    out_count_nxt  = out_count_r;
    if (load_out) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = status_r;
      out_count_nxt  = count_r;
      if (status_r == STATUS_OK && op_r == OP_INSERT) begin
        out_bmin_nxt = bmin_r;
        out_pred_nxt = pred_r;
        out_succ_nxt = succ_r;
      end else begin
        out_bmin_nxt = 1'b0;
        out_pred_nxt = '0;
        out_succ_nxt = '0;
      end
      out_min_nxt = (status_r == STATUS_OK && op_r == OP_QUERY) ? min_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      cfg_r       <= CFG_W'(1);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      cfg_r       <= cfg_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    seg_r        <= seg_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    base_r       <= base_nxt;
    fill_r       <= fill_nxt;
    i_r          <= i_nxt;
    moved_r      <= moved_nxt;
    bmin_r       <= bmin_nxt;
    pred_r       <= pred_nxt;
    succ_r       <= succ_nxt;
    min_r        <= min_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_bmin_r   <= out_bmin_nxt;
    out_pred_r   <= out_pred_nxt;
    out_succ_r   <= out_succ_nxt;
    out_min_r    <= out_min_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_became_minimum  = out_bmin_r;
  assign out_predecessor_key = out_pred_r;
  assign out_successor_key   = out_succ_r;
  assign out_minimum_key     = out_min_r;
  assign out_total_count     = out_count_r;

`ifndef NO_ASSERTIONS
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> (count_r == $past(count_r) + 1'b1))
    else $error("pair count moved by more than one");

  a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (seg_r[0] ? (i_r != '0) : (i_r != LAST_OFF)))
    else $error("segment walk ran past its end");

  a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STATUS_OK) |->
      (out_pred_r == '0 && out_succ_r == '0 && !out_bmin_r && out_min_r == '0))
    else $error("rejected request carries result data");
`endif

endmodule
